/* design/button_setpoint_autorepeat_core_defines.svh */
// ----------------------------------------------------------------------------
// Setpoint keypad core: assertion macros
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BUTTON_SETPOINT_AUTOREPEAT_CORE_DEFINES_SVH
`define BUTTON_SETPOINT_AUTOREPEAT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every rising clock edge outside reset
`define BSA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bsa assertion failed");

// Check that cond implies prop at the same edge outside reset
`define BSA_ASSERT_IMPL(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("bsa assertion failed");

`else

`define BSA_ASSERT(lbl, clk, rst_n, prop)
`define BSA_ASSERT_IMPL(lbl, clk, rst_n, cond, prop)

`endif

`endif

/* design/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// Setpoint keypad package
// Constants, register codes and the structs shared by the keypad modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Timing of the hold behavior, counted in acted ticks
  localparam logic [8:0] LONG_PRESS_TICKS = 9'd500;
  localparam logic [5:0] REPEAT_PERIOD    = 6'd50;
  localparam logic [3:0] COARSE_AFTER     = 4'd10;
  localparam logic [5:0] FIRST_STEP_AT    = 6'd5;
  localparam logic [7:0] IDLE_FIRE        = 8'hFE;
  localparam logic [7:0] IDLE_TOP         = 8'hFF;

  // Register reset values
  localparam logic [14:0]        FINE_STEP_RST  = 15'd26;
  localparam logic [14:0]        COARSE_STEP_RST = 15'd256;
  localparam logic signed [15:0] SP_MIN_RST     = 16'sd0;
  localparam logic signed [15:0] SP_MAX_RST     = 16'sd25600;
  localparam logic signed [15:0] SP_START_RST   = 16'sd0;

  // Register indexes of the configuration port
  localparam int unsigned    CFG_IDX_W       = 3;
  localparam logic [2:0]     CFG_FINE_STEP   = 3'd0;
  localparam logic [2:0]     CFG_COARSE_STEP = 3'd1;
  localparam logic [2:0]     CFG_SP_MIN      = 3'd2;
  localparam logic [2:0]     CFG_SP_MAX      = 3'd3;
  localparam logic [2:0]     CFG_SP_START    = 3'd4;

  typedef struct packed {
    logic [14:0]        fine_step;
    logic [14:0]        coarse_step;
    logic signed [15:0] sp_min;
    logic signed [15:0] sp_max;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic signed [15:0] value;
  } sp_load_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        mid_pressed;
    logic        up_pressed;
    logic        down_pressed;
  } tick_t;

  typedef struct packed {
    logic               acted;
    logic signed [15:0] setpoint;
    logic               setpoint_changed;
    logic               store_setpoint;
    logic               enable_heater;
    logic               reset_timer;
  } result_t;

endpackage

/* design/bsa_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Setpoint keypad configuration registers
// Holds step sizes and clamp limits; a start write loads the setpoint.
// ----------------------------------------------------------------------------
module bsa_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  output bsa_pkg::cfg_t                   cfg_o,
  output bsa_pkg::sp_load_t               sp_load_o
);

  bsa_pkg::cfg_t cfg_q;
  logic          wr_en;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Update the addressed register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fine_step   <= bsa_pkg::FINE_STEP_RST;
      cfg_q.coarse_step <= bsa_pkg::COARSE_STEP_RST;
      cfg_q.sp_min      <= bsa_pkg::SP_MIN_RST;
      cfg_q.sp_max      <= bsa_pkg::SP_MAX_RST;
    end else if (wr_en) begin
      unique case (cfg_index_i)
        bsa_pkg::CFG_FINE_STEP:   cfg_q.fine_step   <= cfg_data_i[14:0];
        bsa_pkg::CFG_COARSE_STEP: cfg_q.coarse_step <= cfg_data_i[14:0];
        bsa_pkg::CFG_SP_MIN:      cfg_q.sp_min      <= $signed(cfg_data_i);
        bsa_pkg::CFG_SP_MAX:      cfg_q.sp_max      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // A start write goes straight to the setpoint register
  assign sp_load_o.load  = wr_en && (cfg_index_i == bsa_pkg::CFG_SP_START);
  assign sp_load_o.value = $signed(cfg_data_i);

endmodule

/* design/bsa_tick_core.sv */
// ----------------------------------------------------------------------------
// Setpoint keypad tick logic
// Time gate, hold counters, auto-repeat stepping with clamp, idle timeout.
// ----------------------------------------------------------------------------
module bsa_tick_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bsa_pkg::tick_t    tick_i,
  input  bsa_pkg::cfg_t     cfg_i,
  input  bsa_pkg::sp_load_t sp_load_i,
  output bsa_pkg::result_t  result_o
);

  logic [31:0]        last_q, last_d;
  logic [8:0]         mid_cnt_q, mid_cnt_d;
  logic [5:0]         held_q, held_d;
  logic [3:0]         rep_q, rep_d;
  logic [7:0]         idle_q, idle_d;
  logic signed [15:0] sp_q, sp_d;

  logic [31:0]        gap;
  logic               pass;
  logic               act;
  logic [8:0]         mid_inc;
  logic [5:0]         held_base;
  logic               coarse;
  logic [14:0]        mag;
  logic signed [17:0] sp_ext, mag_ext, min_ext, max_ext, sum, lo_clamp, hi_clamp;
  logic               changed, store, rtimer;

  // Time gate on the wrapping difference
  assign gap  = tick_i.now_ms - last_q;
  assign pass = gap > 32'd1;
  assign act  = fire_i & pass;

  // Step size and clamped step result
  assign coarse   = rep_q > bsa_pkg::COARSE_AFTER;
  assign mag      = coarse ? cfg_i.coarse_step : cfg_i.fine_step;
  assign sp_ext   = {{2{sp_q[15]}}, sp_q};
  assign mag_ext  = $signed({3'b000, mag});
  assign min_ext  = {{2{cfg_i.sp_min[15]}}, cfg_i.sp_min};
  assign max_ext  = {{2{cfg_i.sp_max[15]}}, cfg_i.sp_max};
  assign sum      = tick_i.up_pressed ? (sp_ext + mag_ext) : (sp_ext - mag_ext);
  assign lo_clamp = (sum < min_ext) ? min_ext : sum;
  assign hi_clamp = (lo_clamp > max_ext) ? max_ext : lo_clamp;

  assign mid_inc   = mid_cnt_q + 9'd1;
  assign held_base = (held_q >= bsa_pkg::REPEAT_PERIOD) ? 6'd0 : held_q;

  // Next state and pulses for one tick
  always_comb begin
    last_d    = last_q;
    mid_cnt_d = mid_cnt_q;
    held_d    = held_q;
    rep_d     = rep_q;
    idle_d    = idle_q;
    sp_d      = sp_q;
    changed   = 1'b0;
    store     = 1'b0;
    rtimer    = 1'b0;
    if (act) begin
      last_d = tick_i.now_ms;
      // Long middle press
      if (tick_i.mid_pressed) begin
        if (mid_inc >= bsa_pkg::LONG_PRESS_TICKS) begin
          mid_cnt_d = 9'd0;
          rtimer    = 1'b1;
        end else begin
          mid_cnt_d = mid_inc;
        end
      end else begin
        mid_cnt_d = 9'd0;
      end
      // Auto-repeat or idle count
      if (tick_i.up_pressed || tick_i.down_pressed) begin
        if (held_q == bsa_pkg::FIRST_STEP_AT) begin
          if (!coarse) begin
            rep_d = rep_q + 4'd1;
          end
          sp_d    = hi_clamp[15:0];
          idle_d  = 8'd0;
          changed = 1'b1;
        end
        held_d = held_base + 6'd1;
      end else begin
        held_d = 6'd0;
        rep_d  = 4'd0;
        store  = (idle_q == bsa_pkg::IDLE_FIRE);
        if (idle_q < bsa_pkg::IDLE_TOP) begin
          idle_d = idle_q + 8'd1;
        end
      end
    end
    // A start write overrides the setpoint
    if (sp_load_i.load) begin
      sp_d = sp_load_i.value;
    end
  end

  // Hold the keypad state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 32'd0;
      mid_cnt_q <= 9'd0;
      held_q    <= 6'd0;
      rep_q     <= 4'd0;
      idle_q    <= bsa_pkg::IDLE_TOP;
      sp_q      <= bsa_pkg::SP_START_RST;
    end else begin
      last_q    <= last_d;
      mid_cnt_q <= mid_cnt_d;
      held_q    <= held_d;
      rep_q     <= rep_d;
      idle_q    <= idle_d;
      sp_q      <= sp_d;
    end
  end

  assign result_o.acted            = pass;
  assign result_o.setpoint         = sp_d;
  assign result_o.setpoint_changed = changed;
  assign result_o.store_setpoint   = store;
  assign result_o.enable_heater    = store;
  assign result_o.reset_timer      = rtimer;

endmodule

/* design/button_setpoint_autorepeat_core.sv */
// ----------------------------------------------------------------------------
// Setpoint keypad core
// Button ticks in, one status result per tick out, with auto-repeat stepping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one tick (timestamp and the
//   three button levels). Output channel: out_valid_o / out_stall_i carry one
//   result per tick. A transfer happens when valid is high and stall is low.
//   Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
//   write it only while no tick is in flight. cfg_ready_o is always high.
//   Pipeline: a transferred tick loads the input register, its result is then
//   registered in the result register, and out_valid_o rises with it.
//   Throughput: one tick per cycle while out_stall_i is low, set by the state
//   update that sits between the input register and the result register.
//   Stall: when out_stall_i holds a result, the input register fills and
//   in_stall_o rises; nothing is dropped.
//   Reset: both registers empty, counters cleared, idle counter at its top,
//   configuration at its defaults, setpoint at zero. No clearing pass.
// ----------------------------------------------------------------------------
`include "button_setpoint_autorepeat_core_defines.svh"

module button_setpoint_autorepeat_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   now_ms_i,
  input  logic                          mid_pressed_i,
  input  logic                          up_pressed_i,
  input  logic                          down_pressed_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          acted_o,
  output logic signed [15:0]            setpoint_o,
  output logic                          setpoint_changed_o,
  output logic                          store_setpoint_o,
  output logic                          enable_heater_o,
  output logic                          reset_timer_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  bsa_pkg::tick_t    tick_q;
  logic              s1_valid_q;
  bsa_pkg::result_t  res_q, res_d;
  logic              out_valid_q;
  logic              advance, fire, in_xfer;
  bsa_pkg::cfg_t     cfg;
  bsa_pkg::sp_load_t sp_load;
  logic              any_pulse;

  // Pipeline control
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q.now_ms       <= now_ms_i;
      tick_q.mid_pressed  <= mid_pressed_i;
      tick_q.up_pressed   <= up_pressed_i;
      tick_q.down_pressed <= down_pressed_i;
    end
  end

  bsa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .sp_load_o   (sp_load)
  );

  bsa_tick_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .tick_i    (tick_q),
    .cfg_i     (cfg),
    .sp_load_i (sp_load),
    .result_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign acted_o            = res_q.acted;
  assign setpoint_o         = res_q.setpoint;
  assign setpoint_changed_o = res_q.setpoint_changed;
  assign store_setpoint_o   = res_q.store_setpoint;
  assign enable_heater_o    = res_q.enable_heater;
  assign reset_timer_o      = res_q.reset_timer;

  assign any_pulse = setpoint_changed_o || store_setpoint_o || reset_timer_o;

  // Pulses only come from ticks that passed the time gate
  `BSA_ASSERT_IMPL(a_pulse_needs_act, clk_i, rst_ni, out_valid_o && any_pulse, acted_o)
  // Idle timeout drives both pulses together
  `BSA_ASSERT_IMPL(a_store_heat_pair, clk_i, rst_ni, out_valid_o, store_setpoint_o == enable_heater_o)
  // Input backpressure only comes from a held result
  `BSA_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Setpoint keypad core testbench
// Drives button ticks through the core with random gaps and output stalls.
// Every result is checked against a cycle-free model of the hold, repeat,
// long-press and idle-timeout behavior. Register settings change between
// phases. The settings include the step and limit extremes and a minimum
// above the maximum.
// ----------------------------------------------------------------------------
module testbench;

  // Spare register indexes above the last real register
  localparam logic [2:0] CFG_SPARE = bsa_pkg::CFG_SP_START + 3'd1;

  typedef struct {
    bit               pinned;
    bsa_pkg::result_t status;
  } fixed_status_t;

  typedef struct {
    bsa_pkg::tick_t tick;
    fixed_status_t  fixed;
  } script_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        now_ms_i = '0;
  logic               mid_pressed_i = 1'b0;
  logic               up_pressed_i = 1'b0;
  logic               down_pressed_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               acted_o;
  logic signed [15:0] setpoint_o;
  logic               setpoint_changed_o;
  logic               store_setpoint_o;
  logic               enable_heater_o;
  logic               reset_timer_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  // Model copy of the registers and the keypad state
  logic [14:0]        step_fine = bsa_pkg::FINE_STEP_RST;
  logic [14:0]        step_coarse = bsa_pkg::COARSE_STEP_RST;
  logic signed [15:0] sp_lo = bsa_pkg::SP_MIN_RST;
  logic signed [15:0] sp_hi = bsa_pkg::SP_MAX_RST;
  logic signed [15:0] sp_cur = bsa_pkg::SP_START_RST;
  logic [31:0]        last_ms = '0;
  logic [8:0]         mid_ticks = '0;
  logic [5:0]         hold_ticks = '0;
  logic [3:0]         repeats = '0;
  logic [7:0]         idle_ticks = bsa_pkg::IDLE_TOP;

  bsa_pkg::result_t status_due_q[$];
  fixed_status_t    fixed_q[$];
  script_row_t      script[23];
  int               mismatches = 0;

  // Stimulus bookkeeping and pacing controls
  logic [31:0] tick_ms = '0;
  int          tick_cnt = 0;
  bit          calm = 1'b0;
  int          hold_ask = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  button_setpoint_autorepeat_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .now_ms_i           (now_ms_i),
    .mid_pressed_i      (mid_pressed_i),
    .up_pressed_i       (up_pressed_i),
    .down_pressed_i     (down_pressed_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .acted_o            (acted_o),
    .setpoint_o         (setpoint_o),
    .setpoint_changed_o (setpoint_changed_o),
    .store_setpoint_o   (store_setpoint_o),
    .enable_heater_o    (enable_heater_o),
    .reset_timer_o      (reset_timer_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Advance the keypad state by one tick and return the status it yields
  function automatic bsa_pkg::result_t next_status(bsa_pkg::tick_t t);
    bsa_pkg::result_t r;
    int               mag;
    int               v;
    r = '0;
    if (t.now_ms - last_ms > 32'd1) begin
      r.acted = 1'b1;
      last_ms = t.now_ms;
      if (t.mid_pressed) begin
        mid_ticks = mid_ticks + 9'd1;
        if (mid_ticks >= bsa_pkg::LONG_PRESS_TICKS) begin
          mid_ticks = '0;
          r.reset_timer = 1'b1;
        end
      end else begin
        mid_ticks = '0;
      end
      if (t.up_pressed || t.down_pressed) begin
        if (hold_ticks == bsa_pkg::FIRST_STEP_AT) begin
          // Fine steps until the repeat count passes the limit, then coarse
          if (repeats > bsa_pkg::COARSE_AFTER) begin
            mag = int'(step_coarse);
          end else begin
            mag = int'(step_fine);
            repeats = repeats + 4'd1;
          end
          v = t.up_pressed ? int'(sp_cur) + mag : int'(sp_cur) - mag;
          if (v < int'(sp_lo)) v = int'(sp_lo);
          if (v > int'(sp_hi)) v = int'(sp_hi);
          sp_cur = 16'(v);
          idle_ticks = '0;
          r.setpoint_changed = 1'b1;
        end
        if (hold_ticks >= bsa_pkg::REPEAT_PERIOD) hold_ticks = '0;
        hold_ticks = hold_ticks + 6'd1;
      end else begin
        hold_ticks = '0;
        repeats = '0;
        if (idle_ticks == bsa_pkg::IDLE_FIRE) begin
          r.store_setpoint = 1'b1;
          r.enable_heater = 1'b1;
        end
        if (idle_ticks < bsa_pkg::IDLE_TOP) idle_ticks = idle_ticks + 8'd1;
      end
    end
    r.setpoint = sp_cur;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic script_row_t row(logic [31:0] ms, bit m, bit u, bit d,
                                      bit pin = 1'b0, bit act = 1'b0,
                                      logic signed [15:0] sp = '0,
                                      bit chg = 1'b0);
    script_row_t s;
    s.tick = '{ms, m, u, d};
    s.fixed.pinned = pin;
    s.fixed.status = '0;
    s.fixed.status.acted = act;
    s.fixed.status.setpoint = sp;
    s.fixed.status.setpoint_changed = chg;
    return s;
  endfunction

  function automatic logic [31:0] next_ms(logic [31:0] ms);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return ms + $urandom_range(0, 1);
    if (pick < 93) return ms + $urandom_range(2, 30);
    if (pick < 97) return $urandom;
    return ms - $urandom_range(1, 3);
  endfunction

  // Check each result transfer, then log each tick and register transfer
  always @(posedge clk_i) begin : watch
    bsa_pkg::result_t want;
    bsa_pkg::tick_t   tk;
    fixed_status_t    fx;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_due_q.size() == 0) begin
          $error("result transfer with no tick pending");
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          check_field("acted", want.acted, acted_o);
          check_field("setpoint", want.setpoint, setpoint_o);
          check_field("setpoint_changed", want.setpoint_changed, setpoint_changed_o);
          check_field("store_setpoint", want.store_setpoint, store_setpoint_o);
          check_field("enable_heater", want.enable_heater, enable_heater_o);
          check_field("reset_timer", want.reset_timer, reset_timer_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        tk = '{now_ms_i, mid_pressed_i, up_pressed_i, down_pressed_i};
        want = next_status(tk);
        if (fixed_q.size() != 0) begin
          fx = fixed_q.pop_front();
          if (fx.pinned) want = fx.status;
        end
        status_due_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bsa_pkg::CFG_FINE_STEP:   step_fine = cfg_data_i[14:0];
          bsa_pkg::CFG_COARSE_STEP: step_coarse = cfg_data_i[14:0];
          bsa_pkg::CFG_SP_MIN:      sp_lo = cfg_data_i;
          bsa_pkg::CFG_SP_MAX:      sp_hi = cfg_data_i;
          bsa_pkg::CFG_SP_START:    sp_cur = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Stall results at random, hold off on request, release in calm stretches
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 18);
    end
  end

  // Offer one tick, with an occasional gap first, and hold it until transfer
  task automatic offer(bsa_pkg::tick_t t, fixed_status_t fx);
    if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    fixed_q.push_back(fx);
    in_valid_i <= 1'b1;
    now_ms_i <= t.now_ms;
    mid_pressed_i <= t.mid_pressed;
    up_pressed_i <= t.up_pressed;
    down_pressed_i <= t.down_pressed;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic offer_random(bit m, bit u, bit d);
    fixed_status_t fx;
    fx = '{1'b0, '0};
    tick_ms = next_ms(tick_ms);
    tick_cnt++;
    if (tick_cnt == 300) hold_ask <= hold_ask + 1;
    if (tick_cnt == 400) calm <= 1'b1;
    if (tick_cnt == 560) calm <= 1'b0;
    offer('{tick_ms, m, u, d}, fx);
  endtask

  // Hold one button pattern, scrambling a share of the ticks
  task automatic run_episode(int len, bit m, bit u, bit d, int mess_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < mess_pct)
        offer_random(1'($urandom), 1'($urandom), 1'($urandom));
      else
        offer_random(m, u, d);
    end
  endtask

  task automatic run_phase(int budget, bit long_first);
    int start_cnt;
    int pick;
    int dir;
    start_cnt = tick_cnt;
    if (long_first) begin
      // Reach the long press, the coarse steps, then the idle timeout
      run_episode(640, 1'b1, 1'b1, 1'b0, 0);
      run_episode(270, 1'b0, 1'b0, 1'b0, 0);
    end
    while (tick_cnt - start_cnt < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        dir = $urandom_range(0, 9);
        run_episode($urandom_range(3, 120), $urandom_range(0, 99) < 30,
                    dir != 1 && dir != 2 && dir != 3 && dir != 4 || dir == 9,
                    dir >= 1 && dir <= 4 || dir == 9, 3);
      end else if (pick < 70) begin
        run_episode($urandom_range(0, 99) < 15 ? 270 : $urandom_range(1, 40),
                    $urandom_range(0, 99) < 20, 1'b0, 1'b0, 3);
      end else if (pick < 85) begin
        run_episode($urandom_range(1, 30), 1'b1, 1'b0, 1'b0, 3);
      end else begin
        run_episode($urandom_range(1, 20), 1'b0, 1'b0, 1'b0, 100);
      end
    end
  endtask

  // Stop offering and wait until every pending result has been checked
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_regs(logic [14:0] fs, logic [14:0] cs, logic signed [15:0] lo,
                          logic signed [15:0] hi, logic signed [15:0] st);
    drain();
    cfg_write(bsa_pkg::CFG_FINE_STEP, {1'($urandom), fs});
    cfg_write(bsa_pkg::CFG_COARSE_STEP, {1'($urandom), cs});
    cfg_write(CFG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
    cfg_write(bsa_pkg::CFG_SP_MIN, lo);
    cfg_write(bsa_pkg::CFG_SP_MAX, hi);
    cfg_write(bsa_pkg::CFG_SP_START, st);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] lo;
    script = '{
      row(32'd0, 0, 0, 0, 1, 0, 16'sd0, 0),
      row(32'd1, 1, 1, 1, 1, 0, 16'sd0, 0),
      row(32'd2, 0, 0, 0, 1, 1, 16'sd0, 0),
      row(32'hFFFF_FFFF, 0, 0, 0, 1, 1, 16'sd0, 0),
      row(32'd0, 0, 1, 0, 1, 0, 16'sd0, 0),
      row(32'd1, 0, 1, 0, 1, 1, 16'sd0, 0),
      row(32'd3, 0, 1, 0, 1, 1, 16'sd0, 0),
      row(32'd5, 0, 1, 0, 1, 1, 16'sd0, 0),
      row(32'd7, 0, 1, 0, 1, 1, 16'sd0, 0),
      row(32'd9, 0, 1, 0, 1, 1, 16'sd0, 0),
      row(32'd11, 0, 1, 0, 1, 1, 16'sd26, 1),
      row(32'd12, 0, 1, 0, 1, 0, 16'sd26, 0),
      row(32'd13, 0, 1, 1),
      row(32'd20, 0, 0, 1),
      row(32'd30, 0, 0, 0),
      row(32'd40, 0, 0, 1),
      row(32'd42, 0, 0, 1),
      row(32'd44, 0, 0, 1),
      row(32'd46, 0, 0, 1),
      row(32'd48, 0, 0, 1),
      row(32'd50, 0, 0, 1, 1, 1, 16'sd0, 1),
      row(32'd60, 1, 0, 1),
      row(32'h8000_0000, 1, 0, 0)
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset settings: time gate edges, first steps
    foreach (script[i]) offer(script[i].tick, script[i].fixed);
    tick_ms = 32'h8000_0000;

    // Reset limits with a random start, long holds and the idle timeout
    set_regs(bsa_pkg::FINE_STEP_RST, bsa_pkg::COARSE_STEP_RST, bsa_pkg::SP_MIN_RST,
             bsa_pkg::SP_MAX_RST, 16'($urandom_range(0, 25600)));
    run_phase(900, 1'b1);

    // Largest steps against the widest limits
    set_regs(15'h7FFF, 15'h7FFF, 16'sh8000, 16'sh7FFF, 16'($urandom));
    run_phase(50, 1'b0);

    // Minimum above maximum
    lo = 16'($urandom_range(100, 20000));
    set_regs(15'($urandom_range(1, 300)), 15'($urandom_range(1, 3000)), lo,
             lo - 16'($urandom_range(1, 200)), 16'($urandom));
    run_phase(50, 1'b0);

    // Zero steps, then a single-point range
    set_regs(15'd0, 15'd0, 16'sh8000, 16'sh7FFF, 16'($urandom));
    run_phase(50, 1'b0);
    lo = 16'($urandom);
    set_regs(15'($urandom), 15'($urandom), lo, lo, 16'($urandom));
    run_phase(40, 1'b0);

    // Fully random settings
    set_regs(15'($urandom), 15'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom));
    run_phase(80, 1'b0);

    drain();
    @(negedge clk_i);
    if (mismatches == 0)
      $display("button_setpoint_autorepeat_core test passed");
    else
      $display("button_setpoint_autorepeat_core test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("button_setpoint_autorepeat_core test failed");
    $finish;
  end

endmodule
